[rtl/core/indexed_deque_list_top_assert.svh]
// Assertion macros shared by the indexed deque list RTL.
// No dependencies; the including module supplies clock and reset names.
`ifndef INDEXED_DEQUE_LIST_TOP_ASSERT_SVH
`define INDEXED_DEQUE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IDL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("indexed deque list: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IDL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("indexed deque list: next-cycle check failed");

`endif

[rtl/core/idl_pkg.sv]
// Package for the indexed deque list: field widths, command and status codes,
// and the shift control struct. No dependencies.
`default_nettype none

package idl_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned CMD_W        = 3;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned LEN_W        = 5;
    localparam int unsigned ST_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_REMOVE     = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_POP_BACK   = 3'd5
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Broadcast to every cell: which way the row moves in this cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } shift_op_t;

endpackage

`default_nettype wire

[rtl/core/indexed_deque_list_top.sv]
// Indexed deque list: a row of CAPACITY cells with at most one broadcast shift per word.
// The result word is registered and appears in the cycle after the command word is accepted.
// Throughput: one command word per cycle while s_ready is high; cells from the position up shift in parallel.
// Reset: the fill count clears to zero and no result is pending; cell contents are
// left undefined and need no clearing pass, since only entries below the count are read.
`default_nettype none

module indexed_deque_list_top
    import idl_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [CMD_W-1:0]         s_command,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [DATA_W-1:0] s_value_in,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_value_out,
    output logic [LEN_W-1:0]              m_length,
    output logic [ST_W-1:0]               m_status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);

    shift_op_t                op;
    logic [CNT_W-1:0]         eff_pos;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] entry_q [CAPACITY];

    idl_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_position  (s_position),
        .rd_data     (rd_data),
        .op          (op),
        .eff_pos     (eff_pos),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_length    (m_length),
        .m_status    (m_status)
    );

    // The removed value is picked before the row shifts over it.
    assign rd_data = entry_q[eff_pos[IDX_W-1:0]];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = entry_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = entry_q[i+1];
        end

        idl_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .pos        (eff_pos),
            .left_data  (left_data),
            .right_data (right_data),
            .new_data   (s_value_in),
            .entry      (entry_q[i])
        );
    end

endmodule

`default_nettype wire

[rtl/core/idl_cell.sv]
// One storage cell of the indexed deque list row.
// Depends on idl_pkg for widths and the shift control struct.
`default_nettype none

module idl_cell
    import idl_pkg::*;
#(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned INDEX = 0
) (
    input  wire logic                     aclk,
    input  wire shift_op_t                op,
    input  wire logic [CNT_W-1:0]         pos,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [DATA_W-1:0] right_data,
    input  wire logic signed [DATA_W-1:0] new_data,
    output logic signed [DATA_W-1:0]      entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     at_pos;
    logic                     above_pos;

    assign at_pos    = (pos == CNT_W'(INDEX));
    assign above_pos = (pos < CNT_W'(INDEX));

    // Insert moves cells above the position up by one; remove closes the gap.
    always_comb begin
        entry_next = entry_reg;
        if (op.ins) begin
            if (at_pos) begin
                entry_next = new_data;
            end else if (above_pos) begin
                entry_next = left_data;
            end
        end else if (op.rem) begin
            if (at_pos || above_pos) begin
                entry_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[rtl/core/idl_ctrl.sv]
// Command decode, checks, fill count and result register of the deque list.
// Depends on idl_pkg and the assertion macros in indexed_deque_list_top_assert.svh.
`default_nettype none

`include "indexed_deque_list_top_assert.svh"

module idl_ctrl
    import idl_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [CMD_W-1:0]         s_command,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [DATA_W-1:0] rd_data,
    output shift_op_t                     op,
    output logic [CNT_W-1:0]              eff_pos,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_value_out,
    output logic [LEN_W-1:0]              m_length,
    output logic [ST_W-1:0]               m_status
);

    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]         fill_count_reg;
    logic [CNT_W-1:0]         fill_count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] value_out_reg;
    logic [LEN_W-1:0]         length_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic                     accept;
    logic                     is_ins;
    logic                     is_rem;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         fill_x;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pos_x   = CMP_W'(s_position);
    assign fill_x  = CMP_W'(fill_count_reg);
    assign is_ins  = s_command inside {CMD_INSERT, CMD_PUSH_FRONT, CMD_PUSH_BACK};
    assign is_rem  = s_command inside {CMD_REMOVE, CMD_POP_FRONT, CMD_POP_BACK};

    always_comb begin
        case (s_command)
            CMD_INSERT, CMD_REMOVE:        eff_pos = CNT_W'(s_position);
            CMD_PUSH_BACK:                 eff_pos = fill_count_reg;
            CMD_POP_BACK:                  eff_pos = fill_count_reg - 1'b1;
            default:                       eff_pos = '0;
        endcase
    end

    // The full and empty checks take precedence over the position check.
    always_comb begin
        status_next = ST_OK;
        if (is_ins) begin
            if (fill_count_reg >= CNT_W'(CAPACITY)) begin
                status_next = ST_FULL;
            end else if ((s_command == CMD_INSERT) && (pos_x > fill_x)) begin
                status_next = ST_RANGE;
            end
        end else if (is_rem) begin
            if (fill_count_reg == '0) begin
                status_next = ST_EMPTY;
            end else if ((s_command == CMD_REMOVE) && (pos_x >= fill_x)) begin
                status_next = ST_RANGE;
            end
        end
    end

    assign op.ins = accept && is_ins && (status_next == ST_OK);
    assign op.rem = accept && is_rem && (status_next == ST_OK);

    always_comb begin
        fill_count_next = fill_count_reg;
        if (op.ins) begin
            fill_count_next = fill_count_reg + 1'b1;
        end else if (op.rem) begin
            fill_count_next = fill_count_reg - 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_out_reg <= op.rem ? rd_data : '0;
            length_reg    <= LEN_W'(fill_count_next);
            status_reg    <= status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_value_out = value_out_reg;
    assign m_length    = length_reg;
    assign m_status    = status_reg;

    `IDL_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_count_reg <= CNT_W'(CAPACITY))
    `IDL_ASSERT_NEXT(a_ins_grows, aclk, aresetn, op.ins, fill_count_reg == CNT_W'($past(fill_count_reg) + 1'b1))
    `IDL_ASSERT_NEXT(a_reject_holds, aclk, aresetn, accept && (status_next != ST_OK), $stable(fill_count_reg))
    `IDL_ASSERT_NEXT(a_result_shown, aclk, aresetn, accept, out_valid_reg && (length_reg == LEN_W'(fill_count_reg)))

endmodule

`default_nettype wire
